[rtl/ip_wildcard_ban_table_assert.svh]
// Assertion macros for the IPv4 wildcard ban table.
// Included by the top level; no other dependencies.
`ifndef IP_WILDCARD_BAN_TABLE_ASSERT_SVH
`define IP_WILDCARD_BAN_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define IWBT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iwbt assertion failed");
// Next-cycle implication, checked out of reset.
`define IWBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iwbt assertion failed");
`else
`define IWBT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IWBT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/iwbt_pkg.sv]
// Shared types and codes for the IPv4 wildcard ban table.
// Used by iwbt_ctrl, iwbt_dp and ip_wildcard_ban_table; no dependencies.
package iwbt_pkg;

    // Operation codes of an input transfer.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Source of the reported slot index.
    typedef enum logic [1:0] {
        IDX_KEEP  = 2'd0,
        IDX_ZERO  = 2'd1,
        IDX_COUNT = 2'd2,
        IDX_FOUND = 2'd3
    } t_idx_sel;

    // One stored entry: wildcard bits above the address.
    typedef struct packed {
        logic [3:0]  wild;
        logic [31:0] addr;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     scan_en;
        logic     append;
        logic     move_rd;
        logic     move_wr;
        logic     clear;
        logic     res_load;
        t_idx_sel idx_sel;
        t_status  status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic found;
        logic full;
        t_op  op;
    } t_dp_sts;

    // Client address matches an entry on every byte that is not a wildcard.
    function automatic logic wild_match(input t_entry ent, input logic [31:0] client);
        logic ok;
        ok = 1'b1;
        for (int b = 0; b < 4; b++) begin
            if (!ent.wild[b] && (ent.addr[31 - 8*b -: 8] != client[31 - 8*b -: 8])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

[rtl/iwbt_dp.sv]
// Datapath of the IPv4 wildcard ban table: entry memory, scan pipeline,
// fill count and result registers. Depends on iwbt_pkg.
module iwbt_dp #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iwbt_pkg::t_dp_cmd i_cmd,
    output iwbt_pkg::t_dp_sts o_sts,
    input  iwbt_pkg::t_op     i_op,
    input  logic [31:0]       i_ip_address,
    input  logic [3:0]        i_wildcard_bytes,
    output logic [1:0]        o_status,
    output logic [8:0]        o_entry_index,
    output logic [9:0]        o_entry_count
);
    import iwbt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_entry          mem [TABLE_DEPTH];
    t_op             r_op;
    t_entry          r_key;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_scan;
    logic            r_pipe_vld;
    logic [AW-1:0]   r_pipe_idx;
    t_entry          r_rd_data;
    logic            r_found;
    logic [AW-1:0]   r_found_idx;
    logic [AW-1:0]   r_res_idx;
    t_status         r_out_status;
    logic [8:0]      r_out_index;
    logic [9:0]      r_out_count;

    logic            scan_first;
    logic            scan_issue;
    logic            hit;
    logic            take;
    logic [CW-1:0]   cnt_m1;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;
    logic [31:0]     idx_wide;
    logic [31:0]     cnt_wide;

    // Scan control: add and check stop at the first hit, remove keeps the last hit.
    always_comb begin
        scan_first = (r_op != OP_REMOVE);
        scan_issue = i_cmd.scan_en && (r_scan < r_count) && !(r_found && scan_first);
        hit        = (r_op == OP_CHECK) ? wild_match(r_rd_data, r_key.addr)
                                        : (r_rd_data == r_key);
        take       = i_cmd.scan_en && r_pipe_vld && hit && (!scan_first || !r_found);
        cnt_m1     = r_count - CW'(1);
        rd_addr    = i_cmd.move_rd ? cnt_m1[AW-1:0] : r_scan[AW-1:0];
    end

    // Write port: append at the end, or move the last entry into a freed slot.
    always_comb begin
        wr_en   = i_cmd.append || i_cmd.move_wr;
        wr_addr = i_cmd.append ? r_count[AW-1:0] : r_found_idx;
        wr_data = i_cmd.append ? r_key : r_rd_data;
    end

    // Entry memory with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Control state: fill count, read pipeline flag and hit flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_pipe_vld <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.move_wr) begin
                r_count <= cnt_m1;
            end
            if (i_cmd.load) begin
                r_pipe_vld <= 1'b0;
                r_found    <= 1'b0;
            end else begin
                r_pipe_vld <= scan_issue;
                if (take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Payload: operands, scan position, hit slot and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_key.addr <= i_ip_address;
            r_key.wild <= i_wildcard_bytes;
            r_scan     <= '0;
        end else if (scan_issue) begin
            r_scan <= r_scan + CW'(1);
        end
        r_pipe_idx <= r_scan[AW-1:0];
        if (take) begin
            r_found_idx <= r_pipe_idx;
        end
        unique case (i_cmd.idx_sel)
            IDX_KEEP:  r_res_idx <= r_res_idx;
            IDX_ZERO:  r_res_idx <= '0;
            IDX_COUNT: r_res_idx <= r_count[AW-1:0];
            IDX_FOUND: r_res_idx <= r_found_idx;
            default:   r_res_idx <= r_res_idx;
        endcase
        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.status;
            r_out_index  <= idx_wide[8:0];
            r_out_count  <= cnt_wide[9:0];
        end
    end

    // Result fields are the low bits of the internal index and count.
    always_comb begin
        idx_wide = 32'(r_res_idx);
        cnt_wide = 32'(r_count);
    end

    assign o_sts.scan_done = (!r_pipe_vld && (r_scan >= r_count)) || (r_found && scan_first);
    assign o_sts.found     = r_found;
    assign o_sts.full      = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.op        = r_op;
    assign o_status        = r_out_status;
    assign o_entry_index   = r_out_index;
    assign o_entry_count   = r_out_count;

endmodule

[rtl/iwbt_ctrl.sv]
// Controller of the IPv4 wildcard ban table: handshakes and operation sequencing.
// Depends on iwbt_pkg; drives iwbt_dp through command and status structs.
module iwbt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  iwbt_pkg::t_op     i_op,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output iwbt_pkg::t_dp_cmd o_cmd,
    input  iwbt_pkg::t_dp_sts i_sts
);
    import iwbt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_RESP
    } t_state;

    t_state  r_state;
    t_status r_status;
    logic    r_out_valid;

    // Commands follow the state and the datapath status.
    always_comb begin
        o_cmd         = '0;
        o_cmd.idx_sel = IDX_KEEP;
        o_cmd.status  = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
            end
            S_DECIDE: begin
                unique case (i_sts.op)
                    OP_ADD: begin
                        if (!i_sts.found && !i_sts.full) begin
                            o_cmd.append  = 1'b1;
                            o_cmd.idx_sel = IDX_COUNT;
                        end else begin
                            o_cmd.idx_sel = IDX_ZERO;
                        end
                    end
                    OP_REMOVE: begin
                        o_cmd.move_rd = i_sts.found;
                        o_cmd.idx_sel = i_sts.found ? IDX_KEEP : IDX_ZERO;
                    end
                    OP_CHECK: begin
                        o_cmd.idx_sel = i_sts.found ? IDX_FOUND : IDX_ZERO;
                    end
                    OP_CLEAR: begin
                        o_cmd.clear   = 1'b1;
                        o_cmd.idx_sel = IDX_ZERO;
                    end
                    default: ;
                endcase
            end
            S_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
            end
            S_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                o_cmd.idx_sel = IDX_FOUND;
            end
            S_RESP: begin
                o_cmd.res_load = !r_out_valid || i_out_ready;
            end
            default: ;
        endcase
    end

    // State, result status and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= (i_op == OP_CLEAR) ? S_DECIDE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_sts.scan_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_RESP;
                    unique case (i_sts.op)
                        OP_ADD: begin
                            if (i_sts.found) begin
                                r_status <= ST_DUP;
                            end else if (i_sts.full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_OK;
                            end
                        end
                        OP_REMOVE: begin
                            r_status <= i_sts.found ? ST_OK : ST_NOTFOUND;
                            if (i_sts.found) begin
                                r_state <= S_MOVE_WR;
                            end
                        end
                        OP_CHECK: begin
                            r_status <= i_sts.found ? ST_OK : ST_NOTFOUND;
                        end
                        OP_CLEAR: begin
                            r_status <= ST_OK;
                        end
                        default: ;
                    endcase
                end
                S_MOVE_RD: begin
                    r_state <= S_MOVE_WR;
                end
                S_MOVE_WR: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (o_cmd.res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/ip_wildcard_ban_table.sv]
// Top level of the IPv4 wildcard ban table.
// Depends on iwbt_pkg, iwbt_ctrl, iwbt_dp and ip_wildcard_ban_table_assert.svh.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------------
//   in      | i_in_valid / o_in_ready    | i_op, i_ip_address, i_wildcard_bytes
//   out     | o_out_valid / i_out_ready  | o_status, o_entry_index, o_entry_count
//
// One operation at a time. Add, remove and check scan the stored entries through
// the single memory read port, one entry a cycle; add and check stop at the first
// hit, a remove that finds its entry adds a step that moves the last entry into
// the freed slot, an empty table has nothing to scan, and clear skips the scan.
// Reset empties the table at once; the memory itself needs no clearing pass.
// A result waits in the output register while the next operation is accepted.
module ip_wildcard_ban_table #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_ip_address,
    input  logic [3:0]  i_wildcard_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [8:0]  o_entry_index,
    output logic [9:0]  o_entry_count
);
    import iwbt_pkg::*;

`include "ip_wildcard_ban_table_assert.svh"

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_op     op;
    logic    res_failed;
    logic    dp_write;

    assign op = t_op'(i_op);

    // Sequencer.
    iwbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Entry store and scan datapath.
    iwbt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_op             (op),
        .i_ip_address     (i_ip_address),
        .i_wildcard_bytes (i_wildcard_bytes),
        .o_status         (o_status),
        .o_entry_index    (o_entry_index),
        .o_entry_count    (o_entry_count)
    );

    // A failed result on the output, and any command that changes the table.
    assign res_failed = o_out_valid && (o_status != ST_OK);
    assign dp_write   = cmd.clear || cmd.append || cmd.move_wr;

    // The block is busy in the cycle after it takes an operation.
    `IWBT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // Failed operations report slot zero.
    `IWBT_ASSERT_IMPL(a_fail_index_zero, i_clk, i_rst_n, res_failed, o_entry_index == 9'd0)
    // No command that changes the table happens while the scan pipeline is active.
    `IWBT_ASSERT_IMPL(a_no_clear_in_scan, i_clk, i_rst_n, cmd.scan_en, !dp_write)

endmodule
